// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define TAA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tilt angle assertion failed");

// next-cycle implication
`define TAA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tilt angle assertion failed");

`endif

// ===== hw/rtl/taa_pkg.sv =====
// ----------------------------------------------------------------------------
// taa_pkg
// Widths, word types and the arctangent table for the tilt angle block.
// ----------------------------------------------------------------------------
package taa_pkg;

  localparam int SAMPLE_BITS_DEF         = 10;
  localparam int ANGLE_FRACTION_BITS_DEF = 8;

  localparam int LANES        = 3;
  localparam int SCALED_BITS  = 32;
  localparam int ROOT_W       = 32;
  localparam int SQ_W         = 32;
  localparam int REM_W        = 34;
  localparam int XW           = 36;
  localparam int ZW           = 42;
  localparam int ZFRAC        = 32;
  localparam int OUT_W        = 16;
  localparam int CORDIC_STEPS = 32;
  localparam int SERIES_FRAC  = 56;

  localparam logic [ZW-1:0] QUARTER_TURN = ZW'(90) << ZFRAC;

  typedef struct packed {
    logic [LANES-1:0][SQ_W-1:0]        sx;
    logic [LANES-1:0][REM_W-1:0]       rem;
    logic [LANES-1:0][ROOT_W-1:0]      root;
    logic [LANES-1:0][SCALED_BITS-1:0] ax;
    logic                              zero;
  } sqrt_word_t;

  typedef struct packed {
    logic [LANES-1:0][XW-1:0] x;
    logic [LANES-1:0][XW-1:0] y;
    logic [LANES-1:0][ZW-1:0] z;
    logic                     zero;
  } cordic_word_t;

  // pi/4 in Q0.56 by Machin's formula
  function automatic logic [63:0] quarter_pi_q56();
    logic [63:0] a5;
    logic [63:0] a239;
    logic [63:0] p;
    a5 = '0;
    p  = (64'd1 << SERIES_FRAC) / 64'd5;
    for (int n = 0; n < 40; n++) begin
      if (p != 0) begin
        if ((n & 1) != 0) a5 = a5 - p / 64'(2 * n + 1);
        else              a5 = a5 + p / 64'(2 * n + 1);
        p = p / 64'd25;
      end
    end
    a239 = '0;
    p    = (64'd1 << SERIES_FRAC) / 64'd239;
    for (int n = 0; n < 40; n++) begin
      if (p != 0) begin
        if ((n & 1) != 0) a239 = a239 - p / 64'(2 * n + 1);
        else              a239 = a239 + p / 64'(2 * n + 1);
        p = p / 64'd57121;
      end
    end
    return (a5 << 2) - a239;
  endfunction

  localparam logic [63:0] QUARTER_PI_Q56 = quarter_pi_q56();

  // atan(2^-i) in Q0.56, i >= 1
  function automatic logic [63:0] atan_pow2_q56(input int i);
    logic [63:0] acc;
    logic [63:0] t;
    int          sh;
    acc = '0;
    for (int n = 0; n < 32; n++) begin
      sh = i * (2 * n + 1);
      if (sh < 64) begin
        t = ((64'd1 << SERIES_FRAC) >> sh) / 64'(2 * n + 1);
        if ((n & 1) != 0) acc = acc - t;
        else              acc = acc + t;
      end
    end
    return acc;
  endfunction

  // atan(2^-i) in degrees, 32 fraction bits, floored
  function automatic logic [63:0] atan_deg_q32(input int i);
    logic [63:0] num;
    logic [63:0] q;
    logic [63:0] r;
    if (i == 0) begin
      q = 64'd45 << ZFRAC;
    end else begin
      num = 64'd45 * atan_pow2_q56(i);
      q   = num / QUARTER_PI_Q56;
      r   = num % QUARTER_PI_Q56;
      for (int b = 0; b < ZFRAC; b++) begin
        r = r << 1;
        q = q << 1;
        if (r >= QUARTER_PI_Q56) begin
          r = r - QUARTER_PI_Q56;
          q = q | 64'd1;
        end
      end
    end
    return q;
  endfunction

endpackage

// ===== hw/rtl/taa_intf.sv =====
// ----------------------------------------------------------------------------
// Tilt angle channels
// Sample and result channels, valid/ready with payload.
// ----------------------------------------------------------------------------
interface taa_in_if #(
  parameter int SAMPLE_BITS = taa_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] accel_x;
  logic signed [SAMPLE_BITS-1:0] accel_y;
  logic signed [SAMPLE_BITS-1:0] accel_z;

  modport source (output valid, accel_x, accel_y, accel_z, input ready);
  modport sink   (input valid, accel_x, accel_y, accel_z, output ready);
endinterface

interface taa_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] angle_to_x;
  logic [15:0] angle_to_y;
  logic [15:0] angle_to_z;
  logic        zero_vector;

  modport source (output valid, angle_to_x, angle_to_y, angle_to_z, zero_vector,
                  input ready);
  modport sink   (input valid, angle_to_x, angle_to_y, angle_to_z, zero_vector,
                  output ready);
endinterface

// ===== hw/rtl/taa_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// taa_sqrt_cell
// One root bit of the digit-by-digit square root, three lanes, one stage.
// ----------------------------------------------------------------------------
module taa_sqrt_cell #(
  parameter int STEP = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  taa_pkg::sqrt_word_t in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output taa_pkg::sqrt_word_t out_word
);
  import taa_pkg::*;

  localparam int BIT     = ROOT_W - 1 - STEP;
  localparam int LO      = 2 * BIT - ROOT_W;
  localparam int LO_SAFE = (LO < 0) ? 0 : LO;
  localparam int RSH_W   = REM_W + 2;

  sqrt_word_t nxt;

  always_comb begin
    logic [RSH_W-1:0] rem_sh;
    logic [RSH_W-1:0] trial;
    logic [1:0]       pr;
    nxt = in_word;
    for (int l = 0; l < LANES; l++) begin
      // radicand is sx * 2^ROOT_W, so its low half brings down zeros
      pr     = (BIT >= ROOT_W / 2) ? in_word.sx[l][LO_SAFE +: 2] : 2'b00;
      rem_sh = {in_word.rem[l], pr};
      trial  = RSH_W'({in_word.root[l], 2'b01});
      if (rem_sh >= trial) begin
        nxt.rem[l]  = REM_W'(rem_sh - trial);
        nxt.root[l] = {in_word.root[l][ROOT_W-2:0], 1'b1};
      end else begin
        nxt.rem[l]  = rem_sh[REM_W-1:0];
        nxt.root[l] = {in_word.root[l][ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_word <= nxt;
    end
  end

endmodule

// ===== hw/rtl/taa_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// taa_cordic_cell
// One vectoring CORDIC iteration, three lanes, one stage.
// ----------------------------------------------------------------------------
module taa_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  taa_pkg::cordic_word_t in_word,
  output logic                  out_valid,
  input  logic                  out_ready,
  output taa_pkg::cordic_word_t out_word
);
  import taa_pkg::*;

  localparam logic [ZW-1:0] ATAN_STEP = ZW'(atan_deg_q32(STEP));

  cordic_word_t nxt;

  always_comb begin
    logic signed [XW-1:0] xi;
    logic signed [XW-1:0] yi;
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    nxt = in_word;
    for (int l = 0; l < LANES; l++) begin
      xi = in_word.x[l];
      yi = in_word.y[l];
      dx = yi >>> STEP;
      dy = xi >>> STEP;
      if (!yi[XW-1]) begin
        nxt.x[l] = xi + dx;
        nxt.y[l] = yi - dy;
        nxt.z[l] = in_word.z[l] + ATAN_STEP;
      end else begin
        nxt.x[l] = xi - dx;
        nxt.y[l] = yi + dy;
        nxt.z[l] = in_word.z[l] - ATAN_STEP;
      end
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_word <= nxt;
    end
  end

endmodule

// ===== hw/rtl/accel_axis_tilt_angles.sv =====
// ----------------------------------------------------------------------------
// accel_axis_tilt_angles
// Takes one x/y/z acceleration word per clock and returns the angle between
// the vector and each axis, 0 to 180 degrees, unsigned with
// ANGLE_FRACTION_BITS fraction bits, rounded to nearest. The pipeline is
// an input stage that forms the squares, 32 square-root cells (one root
// bit each), 32 CORDIC cells (one iteration each) and the output register.
// The chain is fully pipelined, so a new word is taken every clock;
// under output back-pressure it keeps accepting until its empty stages are
// filled. An all-zero sample returns zero angles with zero_vector set.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module accel_axis_tilt_angles #(
  parameter int SAMPLE_BITS         = taa_pkg::SAMPLE_BITS_DEF,
  parameter int ANGLE_FRACTION_BITS = taa_pkg::ANGLE_FRACTION_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  taa_in_if.sink           sample,
  taa_out_if.source        result
);
  import taa_pkg::*;

  localparam int SCALE    = SCALED_BITS - SAMPLE_BITS;
  localparam int SQ_SHIFT = ROOT_W - 2 * SAMPLE_BITS;
  localparam int SQ_CELLS = ROOT_W;
  localparam logic [ZW-1:0] ROUND_HALF = ZW'(1) << (ZFRAC - 1 - ANGLE_FRACTION_BITS);
  localparam logic [ZW-1:0] ANG_TOP    = ZW'(180) << ANGLE_FRACTION_BITS;

  // input stage
  logic signed [2*SAMPLE_BITS-1:0] sq_x;
  logic signed [2*SAMPLE_BITS-1:0] sq_y;
  logic signed [2*SAMPLE_BITS-1:0] sq_z;
  sqrt_word_t                      front_next;
  sqrt_word_t                      front_word;
  logic                            front_valid;
  logic                            front_ready;

  sqrt_word_t   sq_w [SQ_CELLS+1];
  logic         sq_v [SQ_CELLS+1];
  logic         sq_r [SQ_CELLS+1];
  cordic_word_t fold_word;
  cordic_word_t cw   [CORDIC_STEPS+1];
  logic         cv   [CORDIC_STEPS+1];
  logic         cr   [CORDIC_STEPS+1];

  logic                          res_valid;
  logic                          res_zero;
  logic [LANES-1:0][OUT_W-1:0]   res_angle;
  logic [LANES-1:0][OUT_W-1:0]   res_angle_next;

  assign sq_x = (2*SAMPLE_BITS)'(sample.accel_x) * (2*SAMPLE_BITS)'(sample.accel_x);
  assign sq_y = (2*SAMPLE_BITS)'(sample.accel_y) * (2*SAMPLE_BITS)'(sample.accel_y);
  assign sq_z = (2*SAMPLE_BITS)'(sample.accel_z) * (2*SAMPLE_BITS)'(sample.accel_z);

  always_comb begin
    front_next      = '0;
    front_next.sx[0] = (SQ_W'($unsigned(sq_y)) + SQ_W'($unsigned(sq_z))) << SQ_SHIFT;
    front_next.sx[1] = (SQ_W'($unsigned(sq_x)) + SQ_W'($unsigned(sq_z))) << SQ_SHIFT;
    front_next.sx[2] = (SQ_W'($unsigned(sq_x)) + SQ_W'($unsigned(sq_y))) << SQ_SHIFT;
    front_next.ax[0] = {sample.accel_x, {SCALE{1'b0}}};
    front_next.ax[1] = {sample.accel_y, {SCALE{1'b0}}};
    front_next.ax[2] = {sample.accel_z, {SCALE{1'b0}}};
    front_next.zero  = (sample.accel_x == '0) && (sample.accel_y == '0) &&
                       (sample.accel_z == '0);
  end

  assign front_ready  = !front_valid || sq_r[0];
  assign sample.ready = front_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else if (front_ready) begin
      front_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (front_ready && sample.valid) begin
      front_word <= front_next;
    end
  end

  assign sq_w[0] = front_word;
  assign sq_v[0] = front_valid;

  for (genvar k = 0; k < SQ_CELLS; k++) begin : g_sqrt
    taa_sqrt_cell #(
      .STEP (k)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (sq_v[k]),
      .in_ready  (sq_r[k]),
      .in_word   (sq_w[k]),
      .out_valid (sq_v[k+1]),
      .out_ready (sq_r[k+1]),
      .out_word  (sq_w[k+1])
    );
  end

  // negative axis: start from (h, -a) a quarter turn on
  always_comb begin
    logic signed [SCALED_BITS-1:0] as_l;
    logic signed [XW-1:0]          as_x;
    fold_word      = '0;
    fold_word.zero = sq_w[SQ_CELLS].zero;
    for (int l = 0; l < LANES; l++) begin
      as_l = sq_w[SQ_CELLS].ax[l];
      as_x = XW'(as_l);
      if (as_l[SCALED_BITS-1]) begin
        fold_word.x[l] = XW'(sq_w[SQ_CELLS].root[l]);
        fold_word.y[l] = -as_x;
        fold_word.z[l] = QUARTER_TURN;
      end else begin
        fold_word.x[l] = as_x;
        fold_word.y[l] = XW'(sq_w[SQ_CELLS].root[l]);
        fold_word.z[l] = '0;
      end
    end
  end

  assign cw[0]          = fold_word;
  assign cv[0]          = sq_v[SQ_CELLS];
  assign sq_r[SQ_CELLS] = cr[0];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    taa_cordic_cell #(
      .STEP (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (cv[i]),
      .in_ready  (cr[i]),
      .in_word   (cw[i]),
      .out_valid (cv[i+1]),
      .out_ready (cr[i+1]),
      .out_word  (cw[i+1])
    );
  end

  // round, clamp to [0, 180] degrees
  always_comb begin
    logic signed [ZW-1:0] zi;
    logic [ZW-1:0]        zpos;
    logic [ZW-1:0]        q;
    for (int l = 0; l < LANES; l++) begin
      zi   = cw[CORDIC_STEPS].z[l];
      zpos = zi[ZW-1] ? '0 : zi;
      q    = (zpos + ROUND_HALF) >> (ZFRAC - ANGLE_FRACTION_BITS);
      if (q > ANG_TOP) begin
        q = ANG_TOP;
      end
      res_angle_next[l] = cw[CORDIC_STEPS].zero ? '0 : q[OUT_W-1:0];
    end
  end

  assign cr[CORDIC_STEPS] = !res_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cr[CORDIC_STEPS]) begin
      res_valid <= cv[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (cr[CORDIC_STEPS] && cv[CORDIC_STEPS]) begin
      res_angle <= res_angle_next;
      res_zero  <= cw[CORDIC_STEPS].zero;
    end
  end

  assign result.valid       = res_valid;
  assign result.angle_to_x  = res_angle[0];
  assign result.angle_to_y  = res_angle[1];
  assign result.angle_to_z  = res_angle[2];
  assign result.zero_vector = res_zero;

  logic sample_all_zero;
  logic res_all_zero;
  logic res_in_range;

  assign sample_all_zero = (sample.accel_x == '0) && (sample.accel_y == '0) &&
                           (sample.accel_z == '0);
  assign res_all_zero    = (result.angle_to_x == '0) && (result.angle_to_y == '0) &&
                           (result.angle_to_z == '0);
  assign res_in_range    = (ZW'(result.angle_to_x) <= ANG_TOP) &&
                           (ZW'(result.angle_to_y) <= ANG_TOP) &&
                           (ZW'(result.angle_to_z) <= ANG_TOP);

  `TAA_ASSERT_NEXT(a_zero_tagged, sample.valid && sample.ready && sample_all_zero, front_word.zero)
  `TAA_ASSERT_IMP(a_zero_angles, result.valid && result.zero_vector, res_all_zero)
  `TAA_ASSERT_IMP(a_angle_range, result.valid && (ANG_TOP <= ZW'(65535)), res_in_range)

endmodule
